// ===== design/mttm_pkg.sv =====
// Shared constants, operation codes and command type for the multi-tape Turing machine evaluator.
// No dependencies; used by every module of the block.
package mttm_pkg;

    localparam int STATES        = 16;
    localparam int TAPES         = 2;
    localparam int INPUT_BITS    = 16;
    localparam int PAD_BITS      = 64;
    localparam int STEPS_DEFAULT = 256;

    localparam int OP_W      = 2;
    localparam int TBL_AW    = 6;
    localparam int WORD_W    = 8;
    localparam int PAD_AW    = 6;
    localparam int IN_W      = 32;
    localparam int IN_IW     = $clog2(IN_W);
    localparam int STATE_W   = $clog2(STATES);
    localparam int TBL_DEPTH = STATES << TAPES;
    localparam int LOAD_LEN  = INPUT_BITS + PAD_BITS;
    localparam int SRC_W     = 8;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [OP_W-1:0] OP_TABLE = 2'd0;
    localparam logic [OP_W-1:0] OP_PAD   = 2'd1;
    localparam logic [OP_W-1:0] OP_EVAL  = 2'd2;

    typedef enum logic [1:0] {
        CMD_TABLE,
        CMD_PAD,
        CMD_EVAL
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [TBL_AW-1:0]  table_index;
        logic [WORD_W-1:0]  table_word;
        logic               pad_tape;
        logic [PAD_AW-1:0]  pad_position;
        logic               pad_bit;
        logic [IN_W-1:0]    input_bits;
    } cmd_t;

endpackage

// ===== design/mttm_front.sv =====
// Front end: accepts items, drops those that do nothing, and queues commands for the back end.
// Depends on mttm_pkg.
module mttm_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [mttm_pkg::OP_W-1:0]    operation,
    input  logic [mttm_pkg::TBL_AW-1:0]  table_index,
    input  logic [mttm_pkg::WORD_W-1:0]  table_word,
    input  logic                         pad_tape,
    input  logic [mttm_pkg::PAD_AW-1:0]  pad_position,
    input  logic                         pad_bit,
    input  logic [mttm_pkg::IN_W-1:0]    input_bits,
    output logic                         q_valid,
    output mttm_pkg::cmd_t               q_cmd,
    input  logic                         q_pop
);
    import mttm_pkg::*;

    localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    cmd_t           entry_reg [QUEUE_DEPTH];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0] count_reg, count_next;
    cmd_t           in_cmd;
    logic           keep;
    logic           enq;
    logic           deq;

    always_comb
    begin
        in_cmd.table_index  = table_index;
        in_cmd.table_word   = table_word;
        in_cmd.pad_tape     = pad_tape;
        in_cmd.pad_position = pad_position;
        in_cmd.pad_bit      = pad_bit;
        in_cmd.input_bits   = input_bits;
        in_cmd.kind         = CMD_EVAL;
        keep                = 1'b0;
        unique case (operation)
            OP_TABLE:
            begin
                in_cmd.kind = CMD_TABLE;
                keep        = int'(table_index) < TBL_DEPTH;
            end
            OP_PAD:
            begin
                in_cmd.kind = CMD_PAD;
                keep        = (int'(pad_tape) < TAPES) && (int'(pad_position) < PAD_BITS);
            end
            OP_EVAL:
            begin
                in_cmd.kind = CMD_EVAL;
                keep        = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign full    = count_reg == QCW'(QUEUE_DEPTH);
    assign q_valid = count_reg != '0;
    assign q_cmd   = entry_reg[rd_ptr_reg];
    assign enq     = push && !full && keep;
    assign deq     = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (enq)
        begin
            wr_ptr_next = (int'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + QAW'(1);
        end
        if (deq)
        begin
            rd_ptr_next = (int'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + QAW'(1);
        end
        if (enq && !deq)
        begin
            count_next = count_reg + QCW'(1);
        end
        else if (deq && !enq)
        begin
            count_next = count_reg - QCW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            entry_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

// ===== design/mttm_back.sv =====
// Back end: holds transition table, pad and tape memories, runs the machine and keeps the result register.
// Depends on mttm_pkg.
module mttm_back #(
    parameter int STEPS = mttm_pkg::STEPS_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  mttm_pkg::cmd_t  q_cmd,
    output logic            q_pop,
    output logic            empty,
    input  logic            pop,
    output logic            result_bit
);
    import mttm_pkg::*;

    localparam int TAPE_LEN = ((STEPS + 1) > LOAD_LEN) ? (STEPS + 1) : LOAD_LEN;
    localparam int TAW      = $clog2(TAPE_LEN);
    localparam int LCW      = $clog2(LOAD_LEN + 1);
    localparam int SCW      = $clog2(STEPS + 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_LOAD  = 6'b000010,
        S_START = 6'b000100,
        S_LOOK  = 6'b001000,
        S_EXEC  = 6'b010000,
        S_DONE  = 6'b100000
    } fsm_t;

    logic [WORD_W-1:0] tbl_mem [TBL_DEPTH];
    logic              pad_mem [TAPES][PAD_BITS];
    logic              tape_mem [TAPES][TAPE_LEN];

    fsm_t               fsm_reg, fsm_next;
    logic [LCW-1:0]     cnt_reg, cnt_next;
    logic [SCW-1:0]     step_reg, step_next;
    logic [STATE_W-1:0] mstate_reg, mstate_next;
    logic [TAW-1:0]     head_reg [TAPES];
    logic [TAW-1:0]     head_next [TAPES];
    logic [TAW-1:0]     fill_reg [TAPES];
    logic [TAW-1:0]     fill_next [TAPES];
    logic [TAPES-1:0]   fwd_reg, fwd_next;
    logic [TAPES-1:0]   fbit_reg, fbit_next;
    logic [TAPES-1:0]   rvalid_reg, rvalid_next;
    logic               out_valid_reg, out_valid_next;
    logic [IN_W-1:0]    word_reg, word_next;
    logic               result_reg, result_next;

    logic [WORD_W-1:0]  tbl_q;
    logic [TAPES-1:0]   pad_q;
    logic [TAPES-1:0]   tape_q;

    logic               tbl_we;
    logic               pad_we;
    logic               tape_we;
    logic [TBL_AW-1:0]  tbl_raddr;
    logic [PAD_AW-1:0]  pad_raddr;
    logic [TAW-1:0]     tape_waddr [TAPES];
    logic [TAW-1:0]     tape_raddr [TAPES];
    logic [TAPES-1:0]   tape_wdata;
    logic [TAPES-1:0]   seen;
    logic [TAW-1:0]     step_head [TAPES];
    logic [TAW-1:0]     step_fill [TAPES];
    logic [LCW-1:0]     load_pos;
    logic [TAPES-1:0]   load_bit;
    logic [SRC_W-1:0]   src;

    assign empty      = !out_valid_reg;
    assign result_bit = result_reg;
    assign load_pos   = cnt_reg - LCW'(1);

    always_comb
    begin
        src = '0;
        for (int t = 0; t < TAPES; t++)
        begin
            seen[t] = fwd_reg[t] ? fbit_reg[t] : (rvalid_reg[t] & tape_q[t]);
            src     = SRC_W'(load_pos) + SRC_W'(t * INPUT_BITS);
            if (int'(load_pos) < INPUT_BITS)
            begin
                load_bit[t] = (int'(src) < IN_W) ? word_reg[src[IN_IW-1:0]] : 1'b0;
            end
            else
            begin
                load_bit[t] = pad_q[t];
            end
            if (tbl_q[t])
            begin
                step_head[t] = head_reg[t] + TAW'(1);
            end
            else if (head_reg[t] != '0)
            begin
                step_head[t] = head_reg[t] - TAW'(1);
            end
            else
            begin
                step_head[t] = '0;
            end
            step_fill[t] = (head_reg[t] > fill_reg[t]) ? head_reg[t] : fill_reg[t];
        end
    end

    always_comb
    begin
        fsm_next       = fsm_reg;
        cnt_next       = cnt_reg;
        step_next      = step_reg;
        mstate_next    = mstate_reg;
        head_next      = head_reg;
        fill_next      = fill_reg;
        fwd_next       = fwd_reg;
        fbit_next      = fbit_reg;
        rvalid_next    = rvalid_reg;
        word_next      = word_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg && !pop;
        q_pop          = 1'b0;
        tbl_we         = 1'b0;
        pad_we         = 1'b0;
        tape_we        = 1'b0;
        tbl_raddr      = {mstate_reg, seen};
        pad_raddr      = PAD_AW'(cnt_reg - LCW'(INPUT_BITS));
        tape_waddr     = head_reg;
        tape_raddr     = head_reg;
        tape_wdata     = tbl_q[TAPES +: TAPES];

        unique case (fsm_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    unique case (q_cmd.kind)
                        CMD_TABLE:
                        begin
                            tbl_we = 1'b1;
                        end
                        CMD_PAD:
                        begin
                            pad_we = 1'b1;
                        end
                        CMD_EVAL:
                        begin
                            word_next = q_cmd.input_bits;
                            cnt_next  = '0;
                            fsm_next  = S_LOAD;
                        end
                        default:
                        begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            S_LOAD:
            begin
                tape_we    = cnt_reg != '0;
                tape_wdata = load_bit;
                for (int t = 0; t < TAPES; t++)
                begin
                    tape_waddr[t] = TAW'(load_pos);
                end
                cnt_next = cnt_reg + LCW'(1);
                if (int'(cnt_reg) == LOAD_LEN)
                begin
                    for (int t = 0; t < TAPES; t++)
                    begin
                        head_next[t] = '0;
                        fill_next[t] = TAW'(LOAD_LEN - 1);
                    end
                    mstate_next = '0;
                    step_next   = '0;
                    fsm_next    = S_START;
                end
            end
            S_START:
            begin
                for (int t = 0; t < TAPES; t++)
                begin
                    tape_raddr[t] = '0;
                end
                fwd_next    = '0;
                rvalid_next = '1;
                fsm_next    = S_LOOK;
            end
            S_LOOK:
            begin
                fsm_next = S_EXEC;
            end
            S_EXEC:
            begin
                tape_we     = 1'b1;
                mstate_next = tbl_q[2 * TAPES +: STATE_W];
                step_next   = step_reg + SCW'(1);
                for (int t = 0; t < TAPES; t++)
                begin
                    head_next[t]   = step_head[t];
                    fill_next[t]   = step_fill[t];
                    tape_raddr[t]  = step_head[t];
                    fwd_next[t]    = step_head[t] == head_reg[t];
                    fbit_next[t]   = tbl_q[TAPES + t];
                    rvalid_next[t] = step_head[t] <= step_fill[t];
                end
                fsm_next = (step_reg == SCW'(STEPS - 1)) ? S_DONE : S_LOOK;
            end
            S_DONE:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_valid_next = 1'b1;
                    result_next    = mstate_reg[0];
                    fsm_next       = S_IDLE;
                end
            end
            default:
            begin
                fsm_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg       <= S_IDLE;
            cnt_reg       <= '0;
            step_reg      <= '0;
            mstate_reg    <= '0;
            fwd_reg       <= '0;
            fbit_reg      <= '0;
            rvalid_reg    <= '0;
            out_valid_reg <= 1'b0;
            for (int t = 0; t < TAPES; t++)
            begin
                head_reg[t] <= '0;
                fill_reg[t] <= '0;
            end
        end
        else
        begin
            fsm_reg       <= fsm_next;
            cnt_reg       <= cnt_next;
            step_reg      <= step_next;
            mstate_reg    <= mstate_next;
            fwd_reg       <= fwd_next;
            fbit_reg      <= fbit_next;
            rvalid_reg    <= rvalid_next;
            out_valid_reg <= out_valid_next;
            head_reg      <= head_next;
            fill_reg      <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg   <= word_next;
        result_reg <= result_next;
    end

    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            tbl_mem[q_cmd.table_index] <= q_cmd.table_word;
        end
        tbl_q <= tbl_mem[tbl_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (pad_we)
        begin
            pad_mem[q_cmd.pad_tape][q_cmd.pad_position] <= q_cmd.pad_bit;
        end
        for (int t = 0; t < TAPES; t++)
        begin
            pad_q[t] <= pad_mem[t][pad_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int t = 0; t < TAPES; t++)
        begin
            if (tape_we)
            begin
                tape_mem[t][tape_waddr[t]] <= tape_wdata[t];
            end
            tape_q[t] <= tape_mem[t][tape_raddr[t]];
        end
    end

endmodule

// ===== design/multi_tape_turing_machine_eval_top.sv =====
// Top level of the multi-tape Turing machine evaluator: front end, command queue and back end.
// Depends on mttm_pkg, mttm_front and mttm_back.
//
//   channel   handshake        payload
//   -------   --------------   -------------------------------------------------------
//   input     push / full      operation, table_index, table_word, pad_tape,
//                              pad_position, pad_bit, input_bits
//   result    empty / pop      result_bit (one per evaluate item)
//
// Table and pad writes are made in the back end's idle state as each is taken. An evaluate
// item loads INPUT_BITS + PAD_BITS cells per tape, one cell after another, then runs STEPS
// steps, each paced by the tape read feeding the table read.
// Tapes are never swept clean: a per-tape fill mark makes untouched cells read zero.
// Reset clears queue, sequencer and result flag; memories keep their contents.
// Up to two items queue ahead of the back end; a waiting result holds only the sequencer.
module multi_tape_turing_machine_eval_top #(
    parameter int STEPS = mttm_pkg::STEPS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [mttm_pkg::OP_W-1:0]    operation,
    input  logic [mttm_pkg::TBL_AW-1:0]  table_index,
    input  logic [mttm_pkg::WORD_W-1:0]  table_word,
    input  logic                         pad_tape,
    input  logic [mttm_pkg::PAD_AW-1:0]  pad_position,
    input  logic                         pad_bit,
    input  logic [mttm_pkg::IN_W-1:0]    input_bits,
    output logic                         empty,
    input  logic                         pop,
    output logic                         result_bit
);
    import mttm_pkg::*;

    logic q_valid;
    logic q_pop;
    cmd_t q_cmd;

    mttm_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .operation    (operation),
        .table_index  (table_index),
        .table_word   (table_word),
        .pad_tape     (pad_tape),
        .pad_position (pad_position),
        .pad_bit      (pad_bit),
        .input_bits   (input_bits),
        .q_valid      (q_valid),
        .q_cmd        (q_cmd),
        .q_pop        (q_pop)
    );

    mttm_back #(
        .STEPS (STEPS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_cmd      (q_cmd),
        .q_pop      (q_pop),
        .empty      (empty),
        .pop        (pop),
        .result_bit (result_bit)
    );

endmodule

// ===== design/mttm_checker.sv =====
// Port-level checks for the multi-tape Turing machine evaluator, bound to the top level.
// Depends on mttm_pkg and multi_tape_turing_machine_eval_top.
module mttm_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       push,
    input logic                       full,
    input logic [mttm_pkg::OP_W-1:0]  operation,
    input logic                       empty,
    input logic                       pop,
    input logic                       result_bit
);
    import mttm_pkg::*;

    logic eval_seen_reg, eval_seen_next;

    assign eval_seen_next = eval_seen_reg || (push && !full && operation == OP_EVAL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eval_seen_reg <= 1'b0;
        end
        else
        begin
            eval_seen_reg <= eval_seen_next;
        end
    end

    a_reset_idle: assert property (@(posedge clk) !rst_n |-> (empty && !full))
        else $error("result or full flag shown during reset");

    a_no_result_without_eval: assert property (@(posedge clk) disable iff (!rst_n)
        !eval_seen_reg |-> empty)
        else $error("item shown before any evaluate item was taken");

    a_full_needs_push: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(full) |-> $past(push))
        else $error("queue filled without an accepted item");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result_bit)))
        else $error("waiting item dropped or changed");

endmodule

bind multi_tape_turing_machine_eval_top mttm_checker u_checker (.*);
